[design/cbmap_pkg.sv]
// shared types and constants for the cartridge bank mapper
// no dependencies; imported by cbmap_state, cbmap_xlate, the top level and the testbench

package cbmap_pkg;

   // operation codes carried in req_op
   localparam logic [2:0] OP_CPU_WRITE = 3'd0;
   localparam logic [2:0] OP_CPU_READ  = 3'd1;
   localparam logic [2:0] OP_SCANLINE  = 3'd2;
   localparam logic [2:0] OP_PRG_XLATE = 3'd3;
   localparam logic [2:0] OP_CHR_XLATE = 3'd4;

   // register addresses on the cpu bus
   localparam logic [15:0] ADDR_MUL_LEFT   = 16'h5000;
   localparam logic [15:0] ADDR_MUL_RIGHT  = 16'h5001;
   localparam logic [13:0] ADDR_PRG_PAGE   = 14'h2000;  // $8000-$8003 >> 2
   localparam logic [12:0] ADDR_CHR_LO_PG  = 13'h1200;  // $9000-$9007 >> 3
   localparam logic [12:0] ADDR_CHR_HI_PG  = 13'h1400;  // $A000-$A007 >> 3
   localparam logic [15:0] ADDR_IRQ_OFF    = 16'hC002;
   localparam logic [15:0] ADDR_IRQ_ON_A   = 16'hC003;
   localparam logic [15:0] ADDR_IRQ_ON_B   = 16'hC004;
   localparam logic [15:0] ADDR_IRQ_LOAD   = 16'hC005;
   localparam logic [15:0] ADDR_MODE       = 16'hD000;
   localparam logic [15:0] ADDR_MIRROR     = 16'hD001;

   // prg modes
   localparam logic [1:0] PRG_FIXED_32K = 2'd0;
   localparam logic [1:0] PRG_SWITCH_16K = 2'd1;
   localparam logic [1:0] PRG_FOUR_8K   = 2'd2;
   localparam logic [1:0] PRG_REVERSED  = 2'd3;

   // chr modes
   localparam logic [1:0] CHR_8K = 2'd0;
   localparam logic [1:0] CHR_4K = 2'd1;
   localparam logic [1:0] CHR_2K = 2'd2;
   localparam logic [1:0] CHR_1K = 2'd3;

   // mirroring codes
   localparam logic [1:0] MIRROR_VERTICAL   = 2'd0;
   localparam logic [1:0] MIRROR_HORIZONTAL = 2'd1;
   localparam logic [1:0] MIRROR_ONE_SCREEN = 2'd2;

   localparam logic [7:0] PRG_BANKS_RESET = 8'd16;
   localparam logic [7:0] LAST_BANK_RESET = 8'((2 * 16) - 1);

   typedef struct packed {
      logic [2:0]  op;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic        in_vblank;
   } cbmap_item_type;

   // bank and mode state seen by the translation logic
   typedef struct packed {
      logic [3:0][7:0] prg_bank;
      logic [7:0][7:0] chr_low;
      logic [7:0][7:0] chr_upper;
      logic [1:0]      prg_mode;
      logic            window_on;
      logic            top_switchable;
      logic [1:0]      chr_mode;
   } cbmap_map_type;

endpackage

[design/cbmap_state.sv]
// mapper register file: cpu write decode, multiplier read, scanline irq counter
// depends on cbmap_pkg

module cbmap_state import cbmap_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           exec,
   input  cbmap_item_type item,
   output cbmap_map_type  map,
   output logic [7:0]     read_data,
   output logic           irq_pulse,
   output logic [1:0]     mirroring
);

   logic [3:0][7:0] prg_bank_ff, prg_bank_in;
   logic [7:0][7:0] chr_low_ff, chr_low_in;
   logic [7:0][7:0] chr_upper_ff, chr_upper_in;
   logic [1:0]      prg_mode_ff, prg_mode_in;
   logic            window_ff, window_in;
   logic            top_sw_ff, top_sw_in;
   logic [1:0]      chr_mode_ff, chr_mode_in;
   logic [1:0]      mirror_ff, mirror_in;
   logic [7:0]      mul_left_ff, mul_left_in;
   logic [7:0]      mul_right_ff, mul_right_in;
   logic            irq_on_ff, irq_on_in;
   logic [7:0]      irq_count_ff, irq_count_in;
   logic [7:0]      irq_reload_ff, irq_reload_in;
   logic [15:0]     product;
   logic [15:0]     addr;
   logic [7:0]      wdata;

   assign addr    = item.address;
   assign wdata   = item.write_data;
   assign product = mul_left_ff * mul_right_ff;

   always_comb begin
      prg_bank_in   = prg_bank_ff;
      chr_low_in    = chr_low_ff;
      chr_upper_in  = chr_upper_ff;
      prg_mode_in   = prg_mode_ff;
      window_in     = window_ff;
      top_sw_in     = top_sw_ff;
      chr_mode_in   = chr_mode_ff;
      mirror_in     = mirror_ff;
      mul_left_in   = mul_left_ff;
      mul_right_in  = mul_right_ff;
      irq_on_in     = irq_on_ff;
      irq_count_in  = irq_count_ff;
      irq_reload_in = irq_reload_ff;
      irq_pulse     = 1'b0;
      read_data     = 8'd0;

      if (exec && item.op == OP_CPU_WRITE) begin
         priority if (addr == ADDR_MUL_LEFT) begin
            mul_left_in = wdata;
         end else if (addr == ADDR_MUL_RIGHT) begin
            mul_right_in = wdata;
         end else if (addr[15:2] == ADDR_PRG_PAGE) begin
            prg_bank_in[addr[1:0]] = wdata;
         end else if (addr[15:3] == ADDR_CHR_LO_PG) begin
            chr_low_in[addr[2:0]] = wdata;
         end else if (addr[15:3] == ADDR_CHR_HI_PG) begin
            chr_upper_in[addr[2:0]] = wdata;
         end else if (addr == ADDR_IRQ_OFF) begin
            irq_on_in = 1'b0;
         end else if (addr == ADDR_IRQ_ON_A || addr == ADDR_IRQ_ON_B) begin
            if (!irq_on_ff) begin
               irq_on_in    = 1'b1;
               irq_count_in = irq_reload_ff;
            end
         end else if (addr == ADDR_IRQ_LOAD) begin
            irq_count_in  = wdata;
            irq_reload_in = wdata;
         end else if (addr == ADDR_MODE) begin
            window_in   = wdata[7];
            top_sw_in   = wdata[2];
            prg_mode_in = wdata[1:0];
            chr_mode_in = wdata[4:3];
         end else if (addr == ADDR_MIRROR) begin
            mirror_in = wdata[1:0];
         end else begin
            // unlisted addresses, nametable registers included, are dropped
         end
      end

      if (exec && item.op == OP_CPU_READ) begin
         read_data = (addr == ADDR_MUL_LEFT) ? product[7:0] : addr[15:8];
      end

      if (exec && item.op == OP_SCANLINE && !item.in_vblank && irq_on_ff) begin
         if (irq_count_ff == 8'd0) begin
            irq_pulse     = 1'b1;
            irq_on_in     = 1'b0;
            irq_reload_in = 8'd0;
         end else begin
            irq_count_in = irq_count_ff - 8'd1;
         end
      end
   end

   // reported code follows the select after this word's write
   always_comb begin
      unique case (mirror_in)
         2'd0:    mirroring = MIRROR_VERTICAL;
         2'd1:    mirroring = MIRROR_HORIZONTAL;
         default: mirroring = MIRROR_ONE_SCREEN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            prg_bank_ff[i] <= LAST_BANK_RESET - 8'd3 + 8'(i);
         end
         for (int i = 0; i < 8; i++) begin
            chr_low_ff[i]   <= 8'(i);
            chr_upper_ff[i] <= 8'd0;
         end
         prg_mode_ff   <= PRG_FIXED_32K;
         window_ff     <= 1'b0;
         top_sw_ff     <= 1'b0;
         chr_mode_ff   <= CHR_1K;
         mirror_ff     <= 2'd0;
         mul_left_ff   <= 8'd0;
         mul_right_ff  <= 8'd0;
         irq_on_ff     <= 1'b0;
         irq_count_ff  <= 8'd0;
         irq_reload_ff <= 8'd0;
      end else begin
         prg_bank_ff   <= prg_bank_in;
         chr_low_ff    <= chr_low_in;
         chr_upper_ff  <= chr_upper_in;
         prg_mode_ff   <= prg_mode_in;
         window_ff     <= window_in;
         top_sw_ff     <= top_sw_in;
         chr_mode_ff   <= chr_mode_in;
         mirror_ff     <= mirror_in;
         mul_left_ff   <= mul_left_in;
         mul_right_ff  <= mul_right_in;
         irq_on_ff     <= irq_on_in;
         irq_count_ff  <= irq_count_in;
         irq_reload_ff <= irq_reload_in;
      end
   end

   assign map.prg_bank       = prg_bank_ff;
   assign map.chr_low        = chr_low_ff;
   assign map.chr_upper      = chr_upper_ff;
   assign map.prg_mode       = prg_mode_ff;
   assign map.window_on      = window_ff;
   assign map.top_switchable = top_sw_ff;
   assign map.chr_mode       = chr_mode_ff;

endmodule

[design/cbmap_xlate.sv]
// prg and chr address translation from the current bank and mode state
// depends on cbmap_pkg

module cbmap_xlate import cbmap_pkg::*; (
   input  cbmap_item_type item,
   input  cbmap_map_type  map,
   input  logic [7:0]     last_bank,
   output logic [7:0]     prg_bank,
   output logic           prg_mapped,
   output logic [18:0]    chr_bank
);

   logic [1:0]  prg_slot;
   logic [7:0]  fixed_bank;
   logic [2:0]  chr_slot;
   logic [2:0]  chr_reg;
   logic [15:0] chr_base;
   logic [15:0] addr;

   assign addr       = item.address;
   assign prg_slot   = addr[14:13];
   // slot counted back from the last bank
   assign fixed_bank = last_bank + {6'd0, prg_slot} - 8'd3;

   always_comb begin
      prg_bank   = 8'd0;
      prg_mapped = 1'b0;
      if (item.op == OP_PRG_XLATE) begin
         if (addr[15:13] == 3'b011) begin
            if (map.prg_mode == PRG_FOUR_8K && !map.top_switchable && map.window_on) begin
               prg_bank   = map.prg_bank[3];
               prg_mapped = 1'b1;
            end
         end else if (addr[15]) begin
            prg_mapped = 1'b1;
            unique case (map.prg_mode)
               PRG_FIXED_32K: prg_bank = fixed_bank;
               PRG_SWITCH_16K: begin
                  if (!prg_slot[1]) begin
                     prg_bank = {map.prg_bank[1][6:0], prg_slot[0]};
                  end else begin
                     prg_bank = fixed_bank;
                  end
               end
               PRG_FOUR_8K: begin
                  if (prg_slot == 2'd3 && !map.top_switchable) begin
                     prg_bank = last_bank;
                  end else begin
                     prg_bank = map.prg_bank[prg_slot];
                  end
               end
               default: prg_bank = map.prg_bank[~prg_slot];
            endcase
         end
      end
   end

   assign chr_slot = addr[12:10];

   always_comb begin
      unique case (map.chr_mode)
         CHR_8K:  chr_reg = 3'd0;
         CHR_4K:  chr_reg = chr_slot & 3'b100;
         CHR_2K:  chr_reg = chr_slot & 3'b110;
         default: chr_reg = chr_slot;
      endcase
   end

   assign chr_base = {map.chr_upper[chr_reg], map.chr_low[chr_reg]};

   always_comb begin
      chr_bank = 19'd0;
      if (item.op == OP_CHR_XLATE && addr[15:13] == 3'b000) begin
         unique case (map.chr_mode)
            CHR_8K:  chr_bank = {chr_base, chr_slot};
            CHR_4K:  chr_bank = {1'b0, chr_base, chr_slot[1:0]};
            CHR_2K:  chr_bank = {2'b0, chr_base, chr_slot[0]};
            default: chr_bank = {3'b0, chr_base};
         endcase
      end
   end

endmodule

[design/cartridge_bank_mapper_with_irq_top.sv]
// top level of the cartridge bank mapper: input register, result register, handshakes
// depends on cbmap_pkg, cbmap_state, cbmap_xlate

// The mapper takes one word per clock on the req_ channel and returns one result word
// per accepted word on the rsp_ channel, in order. An accepted word is held in the input
// register until the result register is free or being read, is decoded and executed there
// against the bank, mode and irq state, and is then written into the result register with
// rsp_valid set. One word per cycle is sustained, held off only while rsp_ready is low
// with both registers full.
// The multiplier, write decode and translation are all combinational in the execute step.
// The csr_ port is always ready and loads the PRG ROM size in 16KB units; write it only
// while no word is in flight. There is no clearing pass after reset.

module cartridge_bank_mapper_with_irq_top import cbmap_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_op,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_write_data,
   input  logic        req_in_vblank,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_data,
   output logic [7:0]  rsp_prg_bank,
   output logic        rsp_prg_mapped,
   output logic [18:0] rsp_chr_bank,
   output logic [1:0]  rsp_mirroring,
   output logic        rsp_irq_pulse,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   logic           s1_valid_ff, s1_valid_in;
   cbmap_item_type s1_item_ff, s1_item_in;
   logic           s1_advance;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     banks_16k_ff;
   logic [7:0]     last_bank;
   logic [7:0]     exec_read_data;
   logic           exec_irq_pulse;
   logic [1:0]     exec_mirroring;
   logic [7:0]     exec_prg_bank;
   logic           exec_prg_mapped;
   logic [18:0]    exec_chr_bank;
   cbmap_map_type  map;

   logic [7:0]  read_data_ff;
   logic [7:0]  prg_bank_ff;
   logic        prg_mapped_ff;
   logic [18:0] chr_bank_ff;
   logic [1:0]  mirroring_ff;
   logic        irq_pulse_ff;

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign csr_ready  = 1'b1;
   assign last_bank  = {banks_16k_ff[6:0], 1'b0} - 8'd1;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_item_in  = s1_item_ff;
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
         s1_item_in  = '{op: req_op, address: req_address,
                         write_data: req_write_data, in_vblank: req_in_vblank};
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   cbmap_state u_state (
      .clock     (clock),
      .reset     (reset),
      .exec      (s1_advance),
      .item      (s1_item_ff),
      .map       (map),
      .read_data (exec_read_data),
      .irq_pulse (exec_irq_pulse),
      .mirroring (exec_mirroring)
   );

   cbmap_xlate u_xlate (
      .item       (s1_item_ff),
      .map        (map),
      .last_bank  (last_bank),
      .prg_bank   (exec_prg_bank),
      .prg_mapped (exec_prg_mapped),
      .chr_bank   (exec_chr_bank)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         banks_16k_ff <= PRG_BANKS_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            banks_16k_ff <= csr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_item_ff <= s1_item_in;
      if (s1_advance) begin
         read_data_ff  <= exec_read_data;
         prg_bank_ff   <= exec_prg_bank;
         prg_mapped_ff <= exec_prg_mapped;
         chr_bank_ff   <= exec_chr_bank;
         mirroring_ff  <= exec_mirroring;
         irq_pulse_ff  <= exec_irq_pulse;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = read_data_ff;
   assign rsp_prg_bank   = prg_bank_ff;
   assign rsp_prg_mapped = prg_mapped_ff;
   assign rsp_chr_bank   = chr_bank_ff;
   assign rsp_mirroring  = mirroring_ff;
   assign rsp_irq_pulse  = irq_pulse_ff;

endmodule

[design/cbmap_checker.sv]
// port-level checks for the cartridge bank mapper, bound to the top level
// depends on cartridge_bank_mapper_with_irq_top

module cbmap_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_read_data,
   input logic [7:0]  rsp_prg_bank,
   input logic        rsp_prg_mapped,
   input logic [18:0] rsp_chr_bank,
   input logic [1:0]  rsp_mirroring,
   input logic        rsp_irq_pulse
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_prg_bank)
         && $stable(rsp_chr_bank) && $stable(rsp_read_data) && $stable(rsp_irq_pulse))
      else $error("rsp word changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   a_unmapped_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_prg_mapped |-> rsp_prg_bank == 8'd0)
      else $error("prg bank reported without mapping");

   // an irq word comes from a tick only, so the other results are empty
   a_irq_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_irq_pulse |-> rsp_read_data == 8'd0 && !rsp_prg_mapped
         && rsp_chr_bank == 19'd0)
      else $error("irq pulse mixed with other results");

   a_mirror_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_mirroring != 2'd3)
      else $error("bad mirroring code");

endmodule

bind cartridge_bank_mapper_with_irq_top cbmap_checker u_cbmap_checker (.*);

[tb/tb_top.sv]
// self-checking testbench for cartridge_bank_mapper_with_irq_top: random and directed words
// against an in-bench model of the bank, mode and irq state; depends on cbmap_pkg
`timescale 1ns / 100ps

module tb_top;
   import cbmap_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int WORDS_PER_PHASE = 200;
   localparam int NUM_PHASES = 8;
   localparam logic [15:0] WINDOW_BASE = 16'h6000;
   localparam logic [15:0] ROM_BASE = 16'h8000;
   localparam logic [15:0] CHR_SPACE_END = 16'h2000;
   localparam logic [15:0] NAMETABLE_BASE = 16'hB000;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [7:0]  prg_bank;
      logic        prg_mapped;
      logic [18:0] chr_bank;
      logic [1:0]  mirroring;
      logic        irq_pulse;
   } mapper_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_op = '0;
   logic [15:0] req_address = '0;
   logic [7:0]  req_write_data = '0;
   logic        req_in_vblank = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_read_data;
   logic [7:0]  rsp_prg_bank;
   logic        rsp_prg_mapped;
   logic [18:0] rsp_chr_bank;
   logic [1:0]  rsp_mirroring;
   logic        rsp_irq_pulse;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data = '0;

   // mapper state as the block should hold it
   logic [7:0] rom_16k;
   logic [7:0] prg_regs [4];
   logic [7:0] chr_lo [8];
   logic [7:0] chr_hi [8];
   logic [1:0] prg_mode_q;
   logic       window_on;
   logic       top_sw;
   logic [1:0] chr_mode_q;
   logic [1:0] mirror_sel;
   logic [7:0] mul_a;
   logic [7:0] mul_b;
   logic       irq_en;
   logic [7:0] irq_cnt;
   logic [7:0] irq_preset;

   cbmap_item_type pending_words [$];
   mapper_rsp_type expected_rsps [$];
   int  errors = 0;
   int  idle_cycles = 0;
   bit  req_fire = 1'b0;
   int  req_gap = 0;
   int  req_calm = 0;
   int  rsp_stall = 0;
   int  rsp_calm = 0;

   cartridge_bank_mapper_with_irq_top DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .req_in_vblank  (req_in_vblank),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_data  (rsp_read_data),
      .rsp_prg_bank   (rsp_prg_bank),
      .rsp_prg_mapped (rsp_prg_mapped),
      .rsp_chr_bank   (rsp_chr_bank),
      .rsp_mirroring  (rsp_mirroring),
      .rsp_irq_pulse  (rsp_irq_pulse),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data)
   );

   always #5 clock = ~clock;

   // applies one word to the mapper state and returns the result it must produce
   function automatic mapper_rsp_type map_access(cbmap_item_type w);
      mapper_rsp_type r;
      logic [7:0]  last;
      logic [1:0]  slot;
      logic [2:0]  cslot;
      logic [2:0]  sel;
      logic [15:0] base;
      logic [15:0] prod;
      r = '0;
      last = {rom_16k[6:0], 1'b0} - 8'd1;
      case (w.op)
         OP_CPU_WRITE: begin
            if (w.address == ADDR_MUL_LEFT) mul_a = w.write_data;
            else if (w.address == ADDR_MUL_RIGHT) mul_b = w.write_data;
            else if (w.address[15:2] == ADDR_PRG_PAGE) prg_regs[w.address[1:0]] = w.write_data;
            else if (w.address[15:3] == ADDR_CHR_LO_PG) chr_lo[w.address[2:0]] = w.write_data;
            else if (w.address[15:3] == ADDR_CHR_HI_PG) chr_hi[w.address[2:0]] = w.write_data;
            else if (w.address == ADDR_IRQ_OFF) irq_en = 1'b0;
            else if (w.address == ADDR_IRQ_ON_A || w.address == ADDR_IRQ_ON_B) begin
               // arming reloads the count only from the disarmed state
               if (!irq_en) begin
                  irq_en = 1'b1;
                  irq_cnt = irq_preset;
               end
            end else if (w.address == ADDR_IRQ_LOAD) begin
               irq_cnt = w.write_data;
               irq_preset = w.write_data;
            end else if (w.address == ADDR_MODE) begin
               window_on = w.write_data[7];
               top_sw = w.write_data[2];
               prg_mode_q = w.write_data[1:0];
               chr_mode_q = w.write_data[4:3];
            end else if (w.address == ADDR_MIRROR) mirror_sel = w.write_data[1:0];
         end
         OP_CPU_READ: begin
            prod = mul_a * mul_b;
            r.read_data = (w.address == ADDR_MUL_LEFT) ? prod[7:0] : w.address[15:8];
         end
         OP_SCANLINE: begin
            if (!w.in_vblank && irq_en) begin
               if (irq_cnt == 8'd0) begin
                  r.irq_pulse = 1'b1;
                  irq_preset = 8'd0;
                  irq_en = 1'b0;
               end else irq_cnt = irq_cnt - 8'd1;
            end
         end
         OP_PRG_XLATE: begin
            slot = w.address[14:13];
            if (w.address >= ROM_BASE) begin
               r.prg_mapped = 1'b1;
               case (prg_mode_q)
                  PRG_FIXED_32K: r.prg_bank = last - 8'd3 + slot;
                  PRG_SWITCH_16K: begin
                     r.prg_bank = slot[1] ? last - 8'd3 + slot
                                          : {prg_regs[1][6:0], 1'b0} + slot;
                  end
                  PRG_FOUR_8K: r.prg_bank = (slot == 2'd3 && !top_sw) ? last : prg_regs[slot];
                  default: r.prg_bank = prg_regs[~slot];
               endcase
            end else if (w.address >= WINDOW_BASE && prg_mode_q == PRG_FOUR_8K && !top_sw
                         && window_on) begin
               r.prg_mapped = 1'b1;
               r.prg_bank = prg_regs[3];
            end
         end
         OP_CHR_XLATE: begin
            if (w.address < CHR_SPACE_END) begin
               cslot = w.address[12:10];
               case (chr_mode_q)
                  CHR_8K: sel = 3'd0;
                  CHR_4K: sel = cslot & 3'd4;
                  CHR_2K: sel = cslot & 3'd6;
                  default: sel = cslot;
               endcase
               base = {chr_hi[sel], chr_lo[sel]};
               case (chr_mode_q)
                  CHR_8K: r.chr_bank = {base, 3'b000} + cslot;
                  CHR_4K: r.chr_bank = {base, 2'b00} + cslot[1:0];
                  CHR_2K: r.chr_bank = {base, 1'b0} + cslot[0];
                  default: r.chr_bank = base;
               endcase
            end
         end
         default: ;
      endcase
      r.mirroring = (mirror_sel == 2'd0) ? MIRROR_VERTICAL :
                    (mirror_sel == 2'd1) ? MIRROR_HORIZONTAL : MIRROR_ONE_SCREEN;
      return r;
   endfunction

   // mostly back to back, sometimes short gaps, rarely long ones, with calm stretches
   function automatic int pick_gap(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         calm = $urandom_range(30, 120);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   task automatic push_word(logic [2:0] op, logic [15:0] a, logic [7:0] d, logic vb);
      cbmap_item_type w;
      w.op = op;
      w.address = a;
      w.write_data = d;
      w.in_vblank = vb;
      pending_words.push_back(w);
   endtask

   task automatic push_random();
      int r;
      int n;
      int k;
      logic [15:0] a;
      logic [7:0] d;
      r = $urandom_range(0, 99);
      d = 8'($urandom);
      if (r < 8) begin
         // load, arm and tick around the count, which may or may not reach the interrupt
         n = $urandom_range(0, 5);
         push_word(OP_CPU_WRITE, ADDR_IRQ_LOAD, 8'(n), 1'($urandom));
         push_word(OP_CPU_WRITE, $urandom_range(0, 1) ? ADDR_IRQ_ON_A : ADDR_IRQ_ON_B,
                   8'($urandom), 1'($urandom));
         k = $urandom_range(n, n + 3);
         repeat (k) push_word(OP_SCANLINE, 16'($urandom), 8'($urandom),
                              $urandom_range(0, 5) == 0);
         if ($urandom_range(0, 3) == 0)
            push_word(OP_CPU_WRITE, ADDR_IRQ_OFF, 8'($urandom), 1'($urandom));
      end else if (r < 33) begin
         case ($urandom_range(0, 9))
            0: a = ADDR_MUL_LEFT;
            1: a = ADDR_MUL_RIGHT;
            2: a = {ADDR_PRG_PAGE, 2'($urandom)};
            3: a = {ADDR_CHR_LO_PG, 3'($urandom)};
            4: a = {ADDR_CHR_HI_PG, 3'($urandom)};
            5: begin
               a = ADDR_IRQ_OFF + 16'($urandom_range(0, 3));
               if ($urandom_range(0, 1)) d = 8'($urandom_range(0, 7));
            end
            6: a = ADDR_MODE;
            7: a = ADDR_MIRROR;
            8: a = NAMETABLE_BASE + 16'($urandom_range(0, 7));
            default: a = 16'($urandom);
         endcase
         push_word(OP_CPU_WRITE, a, d, 1'($urandom));
      end else if (r < 43) begin
         a = $urandom_range(0, 1) ? ADDR_MUL_LEFT : 16'($urandom);
         push_word(OP_CPU_READ, a, d, 1'($urandom));
      end else if (r < 58) begin
         push_word(OP_SCANLINE, 16'($urandom), d, $urandom_range(0, 3) == 0);
      end else if (r < 78) begin
         a = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(16'h6000, 16'hFFFF));
         push_word(OP_PRG_XLATE, a, d, 1'($urandom));
      end else if (r < 95) begin
         a = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16'h1FFF));
         push_word(OP_CHR_XLATE, a, d, 1'($urandom));
      end else begin
         push_word(3'($urandom_range(5, 7)), 16'($urandom), d, 1'($urandom));
      end
   endtask

   task automatic wait_drained();
      while (pending_words.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);
   endtask

   // sender: next word from the queue, after a random gap, once the current one is taken
   always @(negedge clock) begin
      cbmap_item_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_words.size() != 0) begin
            w = pending_words.pop_front();
            req_op <= w.op;
            req_address <= w.address;
            req_write_data <= w.write_data;
            req_in_vblank <= w.in_vblank;
            req_valid <= 1'b1;
            req_gap = pick_gap(req_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stalls
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         rsp_stall = pick_gap(rsp_calm);
      end
   end

   task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
         $display("%0t: rsp_%s expected 0x%0h, got 0x%0h", $time, name, exp_v, act_v);
         errors++;
      end
   endtask

   // monitor: predict on every accepted request word, check every result word
   always @(posedge clock) begin
      mapper_rsp_type exp_r;
      bit rsp_fire;
      req_fire = !reset && req_valid && req_ready;
      rsp_fire = !reset && rsp_valid && rsp_ready;
      if (req_fire)
         expected_rsps.push_back(map_access({req_op, req_address, req_write_data,
                                             req_in_vblank}));
      if (rsp_fire) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: result word with none expected, got 0x%0h", $time,
                     {rsp_read_data, rsp_prg_bank, rsp_prg_mapped, rsp_chr_bank,
                      rsp_mirroring, rsp_irq_pulse});
            errors++;
         end else begin
            exp_r = expected_rsps.pop_front();
            check_field("read_data", exp_r.read_data, rsp_read_data);
            check_field("prg_bank", exp_r.prg_bank, rsp_prg_bank);
            check_field("prg_mapped", exp_r.prg_mapped, rsp_prg_mapped);
            check_field("chr_bank", exp_r.chr_bank, rsp_chr_bank);
            check_field("mirroring", exp_r.mirroring, rsp_mirroring);
            check_field("irq_pulse", exp_r.irq_pulse, rsp_irq_pulse);
         end
      end
      if (reset || req_fire || rsp_fire || (csr_valid && csr_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      logic [7:0] rom;
      rom_16k = PRG_BANKS_RESET;
      for (int i = 0; i < 4; i++) prg_regs[i] = LAST_BANK_RESET - 8'd3 + 8'(i);
      for (int i = 0; i < 8; i++) begin
         chr_lo[i] = 8'(i);
         chr_hi[i] = 8'd0;
      end
      prg_mode_q = PRG_FIXED_32K;
      window_on = 1'b0;
      top_sw = 1'b0;
      chr_mode_q = CHR_1K;
      mirror_sel = 2'd0;
      mul_a = 8'd0;
      mul_b = 8'd0;
      irq_en = 1'b0;
      irq_cnt = 8'd0;
      irq_preset = 8'd0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed words at the reset size
      push_word(OP_CPU_WRITE, ADDR_MUL_LEFT, 8'hFF, 1'b0);
      push_word(OP_CPU_WRITE, ADDR_MUL_RIGHT, 8'hFF, 1'b1);
      push_word(OP_CPU_READ, ADDR_MUL_LEFT, 8'h00, 1'b0);
      push_word(OP_CPU_READ, 16'h5FFF, 8'h00, 1'b0);
      push_word(OP_CPU_READ, 16'hFFFF, 8'hFF, 1'b1);
      push_word(OP_CPU_WRITE, NAMETABLE_BASE, 8'hAA, 1'b0);
      push_word(OP_PRG_XLATE, 16'h0000, 8'h00, 1'b0);
      push_word(OP_PRG_XLATE, 16'h5FFF, 8'h00, 1'b0);
      push_word(OP_PRG_XLATE, WINDOW_BASE, 8'h00, 1'b0);
      push_word(OP_PRG_XLATE, ROM_BASE, 8'h00, 1'b0);
      push_word(OP_PRG_XLATE, 16'hFFFF, 8'h00, 1'b0);
      // $6000 window in four-8k mode, then blocked by the switchable top bank
      push_word(OP_CPU_WRITE, ADDR_MODE, 8'h82, 1'b0);
      push_word(OP_PRG_XLATE, WINDOW_BASE, 8'h00, 1'b0);
      push_word(OP_PRG_XLATE, 16'hE000, 8'h00, 1'b0);
      push_word(OP_CPU_WRITE, ADDR_MODE, 8'h86, 1'b0);
      push_word(OP_PRG_XLATE, 16'h7FFF, 8'h00, 1'b0);
      push_word(OP_PRG_XLATE, 16'hE000, 8'h00, 1'b0);
      // reversed prg with 8k chr, all-ones chr base
      push_word(OP_CPU_WRITE, ADDR_MODE, 8'h03, 1'b0);
      push_word(OP_PRG_XLATE, ROM_BASE, 8'h00, 1'b0);
      push_word(OP_CPU_WRITE, {ADDR_CHR_LO_PG, 3'd0}, 8'hFF, 1'b0);
      push_word(OP_CPU_WRITE, {ADDR_CHR_HI_PG, 3'd0}, 8'hFF, 1'b0);
      push_word(OP_CHR_XLATE, 16'h1FFF, 8'h00, 1'b0);
      push_word(OP_CHR_XLATE, CHR_SPACE_END, 8'h00, 1'b0);
      push_word(OP_CPU_WRITE, ADDR_MIRROR, 8'h03, 1'b0);
      // zero count fires on the first tick outside vblank
      push_word(OP_CPU_WRITE, ADDR_IRQ_LOAD, 8'h00, 1'b0);
      push_word(OP_CPU_WRITE, ADDR_IRQ_ON_A, 8'h00, 1'b0);
      push_word(OP_SCANLINE, 16'h0000, 8'h00, 1'b1);
      push_word(OP_SCANLINE, 16'h0000, 8'h00, 1'b0);
      push_word(3'd7, 16'hFFFF, 8'hFF, 1'b1);
      wait_drained();

      for (int p = 0; p < NUM_PHASES; p++) begin
         rom = (p % 3 == 0) ? 8'd2 : (p % 3 == 1) ? 8'd128 : 8'($urandom_range(2, 128));
         @(negedge clock);
         csr_data <= rom;
         csr_valid <= 1'b1;
         do @(posedge clock); while (!csr_ready);
         rom_16k = rom;
         @(negedge clock);
         csr_valid <= 1'b0;
         while (pending_words.size() < WORDS_PER_PHASE) push_random();
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (expected_rsps.size() != 0) begin
         $display("%0t: %0d result words never arrived", $time, expected_rsps.size());
         errors++;
      end
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[files.f]
design/cbmap_pkg.sv
design/cbmap_state.sv
design/cbmap_xlate.sv
design/cartridge_bank_mapper_with_irq_top.sv
design/cbmap_checker.sv
tb/tb_top.sv
